// ===== hdl/gmal_pkg.sv =====
// Package for the gated moving-average level block.
// Holds shared widths, register codes, reset values and divider handshake types.
// No dependencies.
`default_nettype none

package gmal_pkg;

   localparam int DATA_W  = 16;   // Q12.4 distance and register width
   localparam int LEVEL_W = 15;   // Q8 percent
   localparam int COUNT_W = 4;    // reported sample count
   localparam int CSR_IDX_W = 2;
   localparam int DIV_W   = 32;   // divider dividend and quotient width
   localparam int STEP_W  = 6;    // divider step count, up to DIV_W
   localparam int PROD_W  = 31;   // (height - average) * full scale

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 15'd25600;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_HEIGHT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TANK_HEIGHT = 2'd3;

   // Register reset values
   localparam logic [DATA_W-1:0] RST_MIN_DISTANCE    = 16'd32;
   localparam logic [DATA_W-1:0] RST_MAX_DISTANCE    = 16'd6400;
   localparam logic [DATA_W-1:0] RST_TANK_HEIGHT     = 16'd1600;
   localparam logic [DATA_W-1:0] RST_MIN_TANK_HEIGHT = 16'd160;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/gmal_req_if.sv =====
// Input channel of the gated moving-average level block: one distance sample.
// Depends on gmal_pkg.
`default_nettype none

interface gmal_req_if;
   logic                        valid;
   logic                        ready;
   logic [gmal_pkg::DATA_W-1:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

`default_nettype wire

// ===== hdl/gmal_rsp_if.sv =====
// Result channel of the gated moving-average level block.
// Depends on gmal_pkg.
`default_nettype none

interface gmal_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic [gmal_pkg::DATA_W-1:0]  filtered_distance;
   logic [gmal_pkg::LEVEL_W-1:0] level_percent;
   logic                         window_full;
   logic [gmal_pkg::COUNT_W-1:0] sample_count;

   modport source (output valid, output accepted, output filtered_distance,
                   output level_percent, output window_full, output sample_count,
                   input ready);
   modport sink   (input valid, input accepted, input filtered_distance,
                   input level_percent, input window_full, input sample_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/gmal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/gmal_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, 32-bit dividend, 16-bit divisor.
// Depends on gmal_pkg for widths and the request/status structs.
`default_nettype none

module gmal_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gmal_pkg::div_req_type         req,
   input  wire logic [gmal_pkg::DIV_W-1:0]    dividend,
   input  wire logic [gmal_pkg::DATA_W-1:0]   divisor,
   output      gmal_pkg::div_rsp_type         rsp
);

   logic [gmal_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [gmal_pkg::DATA_W:0]   rem_ff, rem_in;
   logic [gmal_pkg::DATA_W-1:0] dsr_ff;
   logic [gmal_pkg::STEP_W-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [gmal_pkg::DATA_W:0]   rem_shift;
   logic [gmal_pkg::STEP_W-1:0] shamt;

   assign shamt     = gmal_pkg::STEP_W'(gmal_pkg::DIV_W) - req.steps;
   assign rem_shift = {rem_ff[gmal_pkg::DATA_W-1:0], quo_ff[gmal_pkg::DIV_W-1]};

   // Trial subtract: keep the difference when the divisor fits.
   always_comb begin
      if (rem_shift >= {1'b0, dsr_ff}) begin
         rem_in = rem_shift - {1'b0, dsr_ff};
         quo_in = {quo_ff[gmal_pkg::DIV_W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift;
         quo_in = {quo_ff[gmal_pkg::DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == gmal_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Align the dividend so its top used bit enters first.
   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= dividend << shamt;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/gated_moving_average_level_core.sv =====
// Gated moving-average level core: top level with sequencer, window store and registers.
// Depends on gmal_pkg, gmal_req_if, gmal_rsp_if, gmal_ram and gmal_divider.
`default_nettype none

// Each distance sample (unsigned Q12.4 cm) is checked against min_distance and
// max_distance. An in-range sample replaces the oldest entry of a WINDOW-deep ring,
// updates a running sum, and the held average becomes sum / filled entries. Each sample,
// accepted or not, produces one result carrying the held average and the tank level,
// ((tank_height - average) * 25600) / tank_height in Q8 percent, clamped to 0..25600;
// the level reads zero before the first accepted sample, for a zero height, a height
// below min_tank_height, or an average at or above the height. One shared serial
// divider, one quotient bit per cycle, does both divisions, and the block takes one
// sample at a time: an accepted sample passes the read, average division, level step,
// level division and output states in turn; a rejected one goes straight to the level
// step. When the level reads zero its division is skipped. The result sits in an output
// register, so the next sample may be taken while a result waits. The user must write
// registers through csr_we/csr_index/csr_wdata only while the block is idle; the block
// itself does not enforce this. Written while idle, they take effect on the next sample.
module gated_moving_average_level_core #(
   parameter int WINDOW = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gmal_req_if.sink                              req_chan,
   gmal_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [gmal_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gmal_pkg::DATA_W-1:0]      csr_wdata
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = gmal_pkg::DATA_W + $clog2(WINDOW);
   localparam int DW     = gmal_pkg::DATA_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_READ     = 3'd1;
   localparam logic [2:0] S_AVG      = 3'd2;
   localparam logic [2:0] S_AVG_WAIT = 3'd3;
   localparam logic [2:0] S_LEVEL    = 3'd4;
   localparam logic [2:0] S_LVL_DIV  = 3'd5;
   localparam logic [2:0] S_LVL_WAIT = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   // Configuration registers
   logic [DW-1:0] min_dist_ff, max_dist_ff, height_ff, min_height_ff;

   // Filter state
   logic [2:0]        state_ff, state_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DW-1:0]     avg_ff;

   // Per-sample working registers
   logic [DW-1:0]                   samp_ff;
   logic                            acc_ff;
   logic [gmal_pkg::PROD_W-1:0]     prod_ff;
   logic [gmal_pkg::LEVEL_W-1:0]    lvl_ff;

   // Output register
   logic                            rsp_valid_ff;
   logic                            rsp_acc_ff;
   logic [DW-1:0]                   rsp_avg_ff;
   logic [gmal_pkg::LEVEL_W-1:0]    rsp_lvl_ff;
   logic                            rsp_full_ff;
   logic [gmal_pkg::COUNT_W-1:0]    rsp_cnt_ff;

   logic                   req_xfer;
   logic                   in_range;
   logic                   ring_full;
   logic                   ring_we;
   logic [DW-1:0]          old_samp;
   logic                   level_zero;
   logic [DW-1:0]          height_diff;
   logic                   out_load;

   gmal_pkg::div_req_type        div_req;
   gmal_pkg::div_rsp_type        div_rsp;
   logic [gmal_pkg::DIV_W-1:0]   div_dividend;
   logic [DW-1:0]                div_divisor;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign in_range       = (req_chan.distance >= min_dist_ff) &&
                           (req_chan.distance <= max_dist_ff);
   assign ring_full      = (count_ff >= CNT_W'(WINDOW));
   assign ring_we        = (state_ff == S_READ);

   assign level_zero  = (count_ff == '0) || (height_ff == '0) ||
                        (height_ff < min_height_ff) || (avg_ff >= height_ff);
   assign height_diff = height_ff - avg_ff;

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Ring read address follows the write slot, so the entry to retire is ready in S_READ.
   gmal_ram #(
      .WIDTH (DW),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (slot_ff),
      .wr_data (samp_ff),
      .rd_addr (slot_ff),
      .rd_data (old_samp)
   );

   // Share one divider between the average and the level.
   always_comb begin
      div_req.start = 1'b0;
      div_req.steps = gmal_pkg::STEP_W'(SUM_W);
      div_dividend  = gmal_pkg::DIV_W'(sum_ff);
      div_divisor   = DW'(count_ff);
      case (state_ff)
         S_AVG: begin
            div_req.start = 1'b1;
         end
         S_LVL_DIV: begin
            div_req.start = 1'b1;
            div_req.steps = gmal_pkg::STEP_W'(gmal_pkg::PROD_W);
            div_dividend  = gmal_pkg::DIV_W'(prod_ff);
            div_divisor   = height_ff;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   gmal_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .rsp      (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = in_range ? S_READ : S_LEVEL;
            end
         end
         S_READ:     state_in = S_AVG;
         S_AVG:      state_in = S_AVG_WAIT;
         S_AVG_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL:    state_in = level_zero ? S_OUT : S_LVL_DIV;
         S_LVL_DIV:  state_in = S_LVL_WAIT;
         S_LVL_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Control state and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sum_ff        <= '0;
         slot_ff       <= '0;
         count_ff      <= '0;
         avg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         min_dist_ff   <= gmal_pkg::RST_MIN_DISTANCE;
         max_dist_ff   <= gmal_pkg::RST_MAX_DISTANCE;
         height_ff     <= gmal_pkg::RST_TANK_HEIGHT;
         min_height_ff <= gmal_pkg::RST_MIN_TANK_HEIGHT;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               gmal_pkg::CSR_MIN_DISTANCE:    min_dist_ff   <= csr_wdata;
               gmal_pkg::CSR_MAX_DISTANCE:    max_dist_ff   <= csr_wdata;
               gmal_pkg::CSR_TANK_HEIGHT:     height_ff     <= csr_wdata;
               gmal_pkg::CSR_MIN_TANK_HEIGHT: min_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         // Retire the oldest entry once the ring is full, then add the new sample.
         if (state_ff == S_READ) begin
            if (ring_full) begin
               sum_ff <= sum_ff - SUM_W'(old_samp) + SUM_W'(samp_ff);
            end else begin
               sum_ff   <= sum_ff + SUM_W'(samp_ff);
               count_ff <= count_ff + 1'b1;
            end
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               slot_ff <= '0;
            end else begin
               slot_ff <= slot_ff + 1'b1;
            end
         end

         if (state_ff == S_AVG_WAIT && div_rsp.done) begin
            avg_ff <= div_rsp.quotient[DW-1:0];
         end

         // Hold the result until the sink takes it.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         samp_ff <= req_chan.distance;
         acc_ff  <= in_range;
      end

      if (state_ff == S_LEVEL) begin
         prod_ff <= gmal_pkg::PROD_W'(height_diff) * gmal_pkg::PROD_W'(gmal_pkg::LEVEL_FULL);
         lvl_ff  <= '0;
      end

      // Clamp to full scale.
      if (state_ff == S_LVL_WAIT && div_rsp.done) begin
         if (div_rsp.quotient > gmal_pkg::DIV_W'(gmal_pkg::LEVEL_FULL)) begin
            lvl_ff <= gmal_pkg::LEVEL_FULL;
         end else begin
            lvl_ff <= div_rsp.quotient[gmal_pkg::LEVEL_W-1:0];
         end
      end

      if (out_load) begin
         rsp_acc_ff  <= acc_ff;
         rsp_avg_ff  <= avg_ff;
         rsp_lvl_ff  <= lvl_ff;
         rsp_full_ff <= ring_full;
         rsp_cnt_ff  <= gmal_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.accepted          = rsp_acc_ff;
   assign rsp_chan.filtered_distance = rsp_avg_ff;
   assign rsp_chan.level_percent     = rsp_lvl_ff;
   assign rsp_chan.window_full       = rsp_full_ff;
   assign rsp_chan.sample_count      = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== bench/gated_moving_average_level_core_tb.sv =====
// Testbench for the gated moving-average level core: directed and random distance samples,
// register phases and output back-pressure, each result checked against a local predictor.
// Depends on gmal_pkg, gmal_req_if, gmal_rsp_if and gated_moving_average_level_core.
`default_nettype none

module gated_moving_average_level_core_tb;

   localparam int WIN_DEPTH    = 8;
   localparam int IDLE_PCT     = 12;     // chance per cycle that a side idles
   localparam int SETTLE_CYC   = 80;     // covers the longest sample latency
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 145;
   localparam int RSP_HOLD_CYC = 400;    // length of the long result hold-off

   // One result as the block reports it.
   typedef struct packed {
      logic                         accepted;
      logic [gmal_pkg::DATA_W-1:0]  filtered_distance;
      logic [gmal_pkg::LEVEL_W-1:0] level_percent;
      logic                         window_full;
      logic [gmal_pkg::COUNT_W-1:0] sample_count;
   } level_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [gmal_pkg::CSR_IDX_W-1:0] csr_index;
   logic [gmal_pkg::DATA_W-1:0]    csr_wdata;

   gmal_req_if req_chan ();
   gmal_rsp_if rsp_chan ();

   gated_moving_average_level_core #(
      .WINDOW (WIN_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, period 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------------------
   // Level predictor: registers, sample window and held average, mirrored from the block.
   // ---------------------------------------------------------------------------------------
   logic [gmal_pkg::DATA_W-1:0] min_dist_q    = gmal_pkg::RST_MIN_DISTANCE;
   logic [gmal_pkg::DATA_W-1:0] max_dist_q    = gmal_pkg::RST_MAX_DISTANCE;
   logic [gmal_pkg::DATA_W-1:0] tank_height_q = gmal_pkg::RST_TANK_HEIGHT;
   logic [gmal_pkg::DATA_W-1:0] min_tank_q    = gmal_pkg::RST_MIN_TANK_HEIGHT;

   logic [gmal_pkg::DATA_W-1:0] window_ring [WIN_DEPTH];
   logic [31:0]                 window_sum   = '0;
   int unsigned                 write_ptr    = 0;
   int unsigned                 fill_count   = 0;
   logic [gmal_pkg::DATA_W-1:0] avg_q        = '0;

   level_result_type expected_levels[$];   // predicted results, oldest first
   int               fail_count   = 0;
   bit               idle_on      = 1'b1;   // clear for a stretch with no idling on either side
   bit               hold_request = 1'b0;   // raised by the back-pressure test
   bit               hold_active  = 1'b0;   // result side held off while set

   initial begin
      foreach (window_ring[i])
         window_ring[i] = '0;
   end

   // Derive the Q8 level from an average, using the present registers.
   function automatic logic [gmal_pkg::LEVEL_W-1:0] level_from_average(
         input logic [gmal_pkg::DATA_W-1:0] avg);
      logic [31:0] h;
      logic [31:0] lvl;
      h = tank_height_q;
      if (fill_count == 0 || h == 0 || h < min_tank_q || avg >= h)
         return '0;
      lvl = ((h - avg) * 32'd25600) / h;
      if (lvl > 32'd25600)
         lvl = 32'd25600;
      return lvl[gmal_pkg::LEVEL_W-1:0];
   endfunction

   // Gate one sample, advance the window when it is in range, and form the result.
   function automatic level_result_type advance_window(input logic [gmal_pkg::DATA_W-1:0] d);
      level_result_type r;
      r.accepted = 1'b0;
      if (d >= min_dist_q && d <= max_dist_q) begin
         r.accepted = 1'b1;
         if (fill_count < WIN_DEPTH)
            fill_count++;
         else
            window_sum -= window_ring[write_ptr];
         window_ring[write_ptr] = d;
         window_sum += d;
         write_ptr = (write_ptr + 1) % WIN_DEPTH;
         avg_q = gmal_pkg::DATA_W'(window_sum / fill_count);
      end
      r.filtered_distance = avg_q;
      r.level_percent     = level_from_average(avg_q);
      r.window_full       = (fill_count >= WIN_DEPTH);
      r.sample_count      = fill_count[gmal_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Shared drivers. All of them are entered and left at a falling edge.
   // ---------------------------------------------------------------------------------------

   // Offer one sample, wait for its transfer, then record the predicted result.
   // Valid stays high on return, so back-to-back samples drop it only for a random idle.
   task automatic send_sample(input logic [gmal_pkg::DATA_W-1:0] d);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.distance <= d;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      expected_levels.push_back(advance_window(d));
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted result, then let the block settle.
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (expected_levels.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // Write all four registers back to back; only called while the block is idle.
   task automatic write_regs(input logic [gmal_pkg::DATA_W-1:0] min_d,
                             input logic [gmal_pkg::DATA_W-1:0] max_d,
                             input logic [gmal_pkg::DATA_W-1:0] height,
                             input logic [gmal_pkg::DATA_W-1:0] min_h);
      logic [gmal_pkg::CSR_IDX_W-1:0] idx [4];
      logic [gmal_pkg::DATA_W-1:0]    val [4];
      idx = '{gmal_pkg::CSR_MIN_DISTANCE, gmal_pkg::CSR_MAX_DISTANCE,
              gmal_pkg::CSR_TANK_HEIGHT, gmal_pkg::CSR_MIN_TANK_HEIGHT};
      val = '{min_d, max_d, height, min_h};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      min_dist_q    = min_d;
      max_dist_q    = max_d;
      tank_height_q = height;
      min_tank_q    = min_h;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: random stalls, plus the long hold-off that the back-pressure test asks for.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_chan.ready <= !(hold_active || (idle_on && $urandom_range(99) < IDLE_PCT));
   end

   // Count the long hold-off in cycles once it is requested.
   always begin
      wait (hold_request);
      hold_active = 1'b1;
      repeat (RSP_HOLD_CYC) @(negedge clock);
      hold_active = 1'b0;
      wait (!hold_request);
   end

   // Compare every result transfer with the oldest prediction, field by field.
   always @(posedge clock) begin
      level_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_levels.size() == 0) begin
            $error("result transfer with no sample pending");
            fail_count++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_chan.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_chan.accepted);
               fail_count++;
            end
            if (rsp_chan.filtered_distance !== want.filtered_distance) begin
               $error("filtered_distance: expected %0d, got %0d",
                      want.filtered_distance, rsp_chan.filtered_distance);
               fail_count++;
            end
            if (rsp_chan.level_percent !== want.level_percent) begin
               $error("level_percent: expected %0d, got %0d",
                      want.level_percent, rsp_chan.level_percent);
               fail_count++;
            end
            if (rsp_chan.window_full !== want.window_full) begin
               $error("window_full: expected %0d, got %0d",
                      want.window_full, rsp_chan.window_full);
               fail_count++;
            end
            if (rsp_chan.sample_count !== want.sample_count) begin
               $error("sample_count: expected %0d, got %0d",
                      want.sample_count, rsp_chan.sample_count);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset registers: reject below and above the limits, accept both limits exactly.
   // The first sample comes before anything was accepted, so its level must read zero.
   task automatic test_reset_limits();
      send_sample(16'd0);
      send_sample(gmal_pkg::RST_MIN_DISTANCE - 16'd1);
      send_sample(gmal_pkg::RST_MIN_DISTANCE);
      send_sample(gmal_pkg::RST_MAX_DISTANCE);
      send_sample(gmal_pkg::RST_MAX_DISTANCE + 16'd1);
      send_sample(16'hFFFF);
   endtask

   // Push enough samples to fill the ring and wrap the write pointer past the start.
   task automatic test_window_wrap();
      logic [gmal_pkg::DATA_W-1:0] seq [8];
      seq = '{16'd1600, 16'd800, 16'd100, 16'd3000, 16'd4000, 16'd50, 16'd1599, 16'd2000};
      foreach (seq[i])
         send_sample(seq[i]);
   endtask

   // Register corners: inverted limits, wide open limits, zero height, height below its
   // minimum, average above the height, and the largest height.
   task automatic test_register_corners();
      drain_block();
      write_regs(16'd5000, 16'd4000, gmal_pkg::RST_TANK_HEIGHT,
                 gmal_pkg::RST_MIN_TANK_HEIGHT);
      send_sample(16'd4500);
      send_sample(16'd5000);

      drain_block();
      write_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_sample(16'd0);
      send_sample(16'hFFFF);

      drain_block();
      write_regs(16'd0, 16'hFFFF, 16'd0, 16'd0);
      send_sample(16'd1234);

      drain_block();
      write_regs(16'd0, 16'hFFFF, 16'd1000, 16'd1001);
      send_sample(16'd10);

      drain_block();
      write_regs(16'd0, 16'hFFFF, 16'd100, 16'd0);
      send_sample(16'hFFFF);

      drain_block();
      write_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      repeat (3) send_sample(16'd0);
   endtask

   // Random phases, each under its own register setting. Unless the limits are inverted, most
   // samples fall inside them, so the average moves; the rest hit the edges or land anywhere.
   task automatic test_random_phases();
      logic [gmal_pkg::DATA_W-1:0] lo, hi, height, min_h, d, tmp;
      int unsigned pick;
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain_block();
         case (p)
            0: begin
               lo = 16'd0; hi = 16'hFFFF; height = 16'hFFFF; min_h = 16'd0;
            end
            1: begin
               lo = 16'hFFFF; hi = 16'hFFFF; height = 16'hFFFF; min_h = 16'hFFFF;
            end
            2: begin
               lo = 16'd0; hi = 16'd0; height = 16'd1; min_h = 16'd1;
            end
            default: begin
               lo     = gmal_pkg::DATA_W'($urandom_range(30000, 0));
               hi     = gmal_pkg::DATA_W'($urandom_range(65535, lo));
               height = gmal_pkg::DATA_W'($urandom_range(65535, 1));
               min_h  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(height, 0));
               if ($urandom_range(9) == 0) begin
                  tmp = lo; lo = hi; hi = tmp;
               end
            end
         endcase
         write_regs(lo, hi, height, min_h);
         // Hold both sides busy for one whole phase.
         idle_on = (p != 5);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 70 && lo <= hi)
               d = gmal_pkg::DATA_W'($urandom_range(hi, lo));
            else if (pick < 80) begin
               case ($urandom_range(3))
                  0: d = lo;
                  1: d = hi;
                  2: d = lo - 16'd1;
                  default: d = hi + 16'd1;
               endcase
            end else
               d = 16'($urandom);
            send_sample(d);
         end
         idle_on = 1'b1;
      end
   endtask

   // Hold off the result side for a long stretch while samples keep coming, so the block
   // fills its output register and stalls its input.
   task automatic test_backpressure();
      drain_block();
      write_regs(gmal_pkg::RST_MIN_DISTANCE, gmal_pkg::RST_MAX_DISTANCE,
                 gmal_pkg::RST_TANK_HEIGHT, gmal_pkg::RST_MIN_TANK_HEIGHT);
      hold_request = 1'b1;
      repeat (8)
         send_sample(gmal_pkg::DATA_W'($urandom_range(gmal_pkg::RST_MAX_DISTANCE,
                                                      gmal_pkg::RST_MIN_DISTANCE)));
      hold_request = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence: reset once, then run every test in turn.
   // ---------------------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = gmal_pkg::CSR_MIN_DISTANCE;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.distance = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_limits();
      test_window_wrap();
      test_register_corners();
      test_backpressure();
      test_random_phases();

      req_chan.valid <= 1'b0;
      while (expected_levels.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_count == 0)
         $display("PASS gated_moving_average_level_core");
      else
         $display("FAIL gated_moving_average_level_core");
      $finish;
   end

   // Timeout far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("FAIL gated_moving_average_level_core");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/gmal_pkg.sv
hdl/gmal_req_if.sv
hdl/gmal_rsp_if.sv
hdl/gmal_ram.sv
hdl/gmal_divider.sv
hdl/gated_moving_average_level_core.sv
bench/gated_moving_average_level_core_tb.sv
